@@ design/sfr_pkg.sv @@
package sfr_pkg;

    typedef enum logic [2:0] {
        ST_START,
        ST_FLAG,
        ST_ADDR,
        ST_CTRL,
        ST_DATA,
        ST_ESC
    } parse_state_t;

    localparam logic [2:0] KIND_PAYLOAD    = 3'd0;
    localparam logic [2:0] KIND_GOOD       = 3'd1;
    localparam logic [2:0] KIND_BAD        = 3'd2;
    localparam logic [2:0] KIND_DUPLICATE  = 3'd3;
    localparam logic [2:0] KIND_DISCONNECT = 3'd4;

    localparam logic [2:0] RESP_READY0     = 3'd0;
    localparam logic [2:0] RESP_REJECT0    = 3'd2;
    localparam logic [2:0] RESP_DISCONNECT = 3'd4;

    localparam logic [1:0] CFG_FLAG       = 2'd0;
    localparam logic [1:0] CFG_ESCAPE     = 2'd1;
    localparam logic [1:0] CFG_ADDRESS    = 2'd2;
    localparam logic [1:0] CFG_DISCONNECT = 2'd3;

    localparam logic [7:0] FLAG_RESET       = 8'h7E;
    localparam logic [7:0] ESCAPE_RESET     = 8'h7D;
    localparam logic [7:0] ADDRESS_RESET    = 8'h03;
    localparam logic [7:0] DISCONNECT_RESET = 8'h0B;

    localparam logic [7:0] SEQ0_CTRL  = 8'h00;
    localparam logic [7:0] SEQ1_CTRL  = 8'h80;
    localparam logic [7:0] STUFF_FLAG = 8'h5E;
    localparam logic [7:0] STUFF_ESC  = 8'h5D;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] escape_byte;
        logic [7:0] sender_address;
        logic [7:0] disconnect_control;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload;
        logic [2:0]  response;
        logic [15:0] frame_length;
    } result_t;

endpackage

@@ design/sfr_in_if.sv @@
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

@@ design/sfr_out_if.sv @@
interface sfr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  payload;
    logic [2:0]  response;
    logic [15:0] frame_length;

    modport source (output valid, output kind, output payload, output response,
                    output frame_length, input ready);
    modport sink (input valid, input kind, input payload, input response,
                  input frame_length, output ready);
endinterface

@@ design/sfr_cfg_regs.sv @@
module sfr_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [7:0]    cfg_data,
    output sfr_pkg::cfg_t cfg
);
    import sfr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_byte          <= FLAG_RESET;
            cfg_reg.escape_byte        <= ESCAPE_RESET;
            cfg_reg.sender_address     <= ADDRESS_RESET;
            cfg_reg.disconnect_control <= DISCONNECT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FLAG:       cfg_reg.flag_byte          <= cfg_data;
                CFG_ESCAPE:     cfg_reg.escape_byte        <= cfg_data;
                CFG_ADDRESS:    cfg_reg.sender_address     <= cfg_data;
                CFG_DISCONNECT: cfg_reg.disconnect_control <= cfg_data;
                default:        cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/sfr_in_reg.sv @@
module sfr_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    sfr_in_if.sink     rx,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] rx_byte
);
    logic       valid_reg;
    logic [7:0] byte_reg;

    assign rx.ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rx.valid && rx.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign rx_byte    = byte_reg;

endmodule

@@ design/sfr_deframer.sv @@
module sfr_deframer (
    input  logic             clk,
    input  logic             rst_n,
    input  sfr_pkg::cfg_t    cfg,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    output logic             emit,
    output sfr_pkg::result_t result
);
    import sfr_pkg::*;

    parse_state_t state_reg, state_next;
    logic         seq_reg, seq_next;
    logic [7:0]   check_reg, check_next;
    logic [7:0]   held_reg, held_next;
    logic         held_valid_reg, held_valid_next;
    logic [15:0]  count_reg, count_next;

    logic [7:0] want;
    logic [7:0] other;
    logic       take;
    logic [7:0] take_value;
    logic       good;

    assign want  = seq_reg ? SEQ1_CTRL : SEQ0_CTRL;
    assign other = seq_reg ? SEQ0_CTRL : SEQ1_CTRL;
    assign good  = held_valid_reg && (count_reg != 16'd0) && (held_reg == check_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_FLAG:
            begin
                if (rx_byte == cfg.sender_address)
                    state_next = ST_ADDR;
                else if (rx_byte != cfg.flag_byte)
                    state_next = ST_START;
            end
            ST_ADDR:
            begin
                if (rx_byte == other)
                    state_next = ST_START;
                else if (rx_byte == want)
                    state_next = ST_CTRL;
                else if (rx_byte == cfg.flag_byte)
                    state_next = ST_FLAG;
                else
                    state_next = ST_START;
            end
            ST_CTRL:
            begin
                if (rx_byte == (cfg.sender_address ^ want))
                    state_next = ST_DATA;
                else if (rx_byte == cfg.flag_byte)
                    state_next = ST_FLAG;
                else
                    state_next = ST_START;
            end
            ST_DATA:
            begin
                if (rx_byte == cfg.escape_byte)
                    state_next = ST_ESC;
                else if (rx_byte == cfg.flag_byte)
                    state_next = ST_START;
            end
            ST_ESC:
            begin
                state_next = ST_DATA;
            end
            default:
            begin
                state_next = (rx_byte == cfg.flag_byte) ? ST_FLAG : ST_START;
            end
        endcase
    end

    always_comb
    begin
        seq_next        = seq_reg;
        check_next      = check_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        count_next      = count_reg;
        emit            = 1'b0;
        result          = '0;
        take            = 1'b0;
        take_value      = rx_byte;

        unique case (state_reg)
            ST_ADDR:
            begin
                if (rx_byte == other)
                begin
                    emit            = 1'b1;
                    result.kind     = KIND_DUPLICATE;
                    result.response = {2'b00, seq_reg};
                end
                else if (rx_byte != want && rx_byte != cfg.flag_byte
                         && rx_byte == cfg.disconnect_control)
                begin
                    emit            = 1'b1;
                    result.kind     = KIND_DISCONNECT;
                    result.response = RESP_DISCONNECT;
                end
            end
            ST_CTRL:
            begin
                if (rx_byte == (cfg.sender_address ^ want))
                begin
                    check_next      = '0;
                    held_next       = '0;
                    held_valid_next = 1'b0;
                    count_next      = '0;
                end
            end
            ST_DATA:
            begin
                if (rx_byte != cfg.escape_byte && rx_byte == cfg.flag_byte)
                begin
                    emit                = 1'b1;
                    result.frame_length = count_reg;
                    if (good)
                    begin
                        seq_next        = !seq_reg;
                        result.kind     = KIND_GOOD;
                        result.response = RESP_READY0 | {2'b00, !seq_reg};
                    end
                    else
                    begin
                        result.kind     = KIND_BAD;
                        result.response = RESP_REJECT0 | {2'b00, seq_reg};
                    end
                end
                else if (rx_byte != cfg.escape_byte)
                begin
                    take = 1'b1;
                end
            end
            ST_ESC:
            begin
                if (rx_byte == STUFF_FLAG)
                begin
                    take       = 1'b1;
                    take_value = cfg.flag_byte;
                end
                else if (rx_byte == STUFF_ESC)
                begin
                    take       = 1'b1;
                    take_value = cfg.escape_byte;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        if (take)
        begin
            if (held_valid_reg)
            begin
                emit           = 1'b1;
                result.kind    = KIND_PAYLOAD;
                result.payload = held_reg;
                check_next     = check_reg ^ held_reg;
                if (count_reg != COUNT_MAX)
                    count_next = count_reg + 16'd1;
            end
            held_next       = take_value;
            held_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_START;
            seq_reg        <= 1'b0;
            check_reg      <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            count_reg      <= '0;
        end
        else if (step)
        begin
            state_reg      <= state_next;
            seq_reg        <= seq_next;
            check_reg      <= check_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            count_reg      <= count_next;
        end
    end

endmodule

@@ design/sfr_out_reg.sv @@
module sfr_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    sfr_out_if.source        tx,
    input  logic             step,
    input  logic             emit,
    input  sfr_pkg::result_t result,
    output logic             free
);
    import sfr_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign free = !valid_reg || tx.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (step)
        begin
            valid_reg <= emit;
        end
        else if (tx.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            data_reg <= result;
        end
    end

    assign tx.valid        = valid_reg;
    assign tx.kind         = data_reg.kind;
    assign tx.payload      = data_reg.payload;
    assign tx.response     = data_reg.response;
    assign tx.frame_length = data_reg.frame_length;

endmodule

@@ design/stuffed_frame_receiver.sv @@
// Stuffed frame receiver: deframes a link byte stream of the form flag,
// address, control, header check, stuffed payload with trailing XOR check,
// flag. Received bytes enter on rx (valid/ready, rx_byte); results leave on
// res (valid/ready, kind, payload, response, frame_length): destuffed payload
// bytes one byte late, then a frame good/bad, duplicate or disconnect report
// carrying the response code to send back.
// Registers flag_byte, escape_byte, sender_address, disconnect_control: write
// via cfg_we/cfg_index/cfg_data only while the block is idle (not enforced).
// Path: a byte is registered in the input register at acceptance; when the
// parser steps on it, its result, if any, is registered in the output register.
// Throughput: one byte per cycle while res is not held off; the input register,
// the parser state and the output register advance together on each step.
// Reset: parser waits for an opening flag, expected sequence zero, registers
// take their default values, both channels empty.
// Stall: while res is held off with a result waiting, one further byte is
// held in the input register, then rx.ready drops until res is taken.
module stuffed_frame_receiver (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    sfr_in_if.sink     rx,
    sfr_out_if.source  res
);
    import sfr_pkg::*;

    cfg_t       cfg;
    logic       byte_valid;
    logic [7:0] byte_held;
    logic       free;
    logic       step;
    logic       emit;
    result_t    result;

    assign step = byte_valid && free;

    sfr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfr_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .advance    (step),
        .byte_valid (byte_valid),
        .rx_byte    (byte_held)
    );

    sfr_deframer u_deframer (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step    (step),
        .rx_byte (byte_held),
        .emit    (emit),
        .result  (result)
    );

    sfr_out_reg u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .tx     (res),
        .step   (step),
        .emit   (emit),
        .result (result),
        .free   (free)
    );

endmodule
